### sv/udprx_pkg.sv
// Shared types, codes and arithmetic helpers of the UDP receive checker.
package udprx_pkg;

    localparam int INDEX_LIMIT = 16;
    localparam int IDX_W = 4;

    localparam logic [15:0] UDP_PROTOCOL = 16'd17;
    localparam logic [15:0] HEADER_BYTES = 16'd8;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    typedef logic [IDX_W-1:0] t_index;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_OPEN    = 2'd1,
        OP_BIND    = 2'd2,
        OP_CLOSE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TABLE_FULL   = 3'd1,
        ST_BAD_SOCKET   = 3'd2,
        ST_IN_USE       = 3'd3,
        ST_SHORT        = 3'd4,
        ST_LEN_MISMATCH = 3'd5,
        ST_CSUM_BAD     = 3'd6,
        ST_UNBOUND      = 3'd7
    } t_status;

    typedef struct packed {
        logic        valid;
        t_opcode     opcode;
        logic [7:0]  data_byte;
        logic        end_of_datagram;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        t_index      socket_id;
        logic [31:0] bind_addr;
        logic [15:0] bind_port;
    } t_req;

    typedef struct packed {
        t_status status;
        t_index  index;
    } t_tbl_resp;

    typedef struct packed {
        logic   hit;
        t_index index;
    } t_lookup;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } t_key;

    typedef struct packed {
        logic        done;
        logic        pass;
        t_status     status;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [15:0] payload_length;
    } t_verdict;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

### sv/udprx_sock_table.sv
// Socket table with open flags, bound endpoints, command handling and port lookup.
module udprx_sock_table #(
    parameter int SOCKET_COUNT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  udprx_pkg::t_req      i_req,
    input  udprx_pkg::t_key      i_rx_key,
    output udprx_pkg::t_tbl_resp o_resp,
    output udprx_pkg::t_lookup   o_rx_hit
);

    localparam int ACTIVE_COUNT = (SOCKET_COUNT < udprx_pkg::INDEX_LIMIT) ?
                                  SOCKET_COUNT : udprx_pkg::INDEX_LIMIT;

    logic [ACTIVE_COUNT-1:0] r_open;
    logic [31:0]             r_addr [ACTIVE_COUNT];
    logic [15:0]             r_port [ACTIVE_COUNT];
    logic [ACTIVE_COUNT-1:0] n_open;
    logic [31:0]             n_addr [ACTIVE_COUNT];
    logic [15:0]             n_port [ACTIVE_COUNT];

    logic [ACTIVE_COUNT-1:0] id_hot;
    logic [ACTIVE_COUNT-1:0] bind_match;
    logic [ACTIVE_COUNT-1:0] rx_match;
    logic                    id_open;
    logic                    free_any;
    udprx_pkg::t_index       free_idx;
    udprx_pkg::t_index       rx_idx;

    always_comb begin
        for (int i = 0; i < ACTIVE_COUNT; i++) begin
            id_hot[i] = (i_req.socket_id == udprx_pkg::t_index'(i));
            bind_match[i] = r_open[i] &&
                            (r_addr[i] == 32'd0 || r_addr[i] == i_req.bind_addr) &&
                            (r_port[i] == i_req.bind_port);
            rx_match[i] = r_open[i] &&
                          (r_addr[i] == 32'd0 || r_addr[i] == i_rx_key.addr) &&
                          (r_port[i] == i_rx_key.port);
        end
        id_open = |(id_hot & r_open);
        free_any = ~(&r_open);
        free_idx = '0;
        rx_idx = '0;
        for (int i = ACTIVE_COUNT - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                free_idx = udprx_pkg::t_index'(i);
            end
            if (rx_match[i]) begin
                rx_idx = udprx_pkg::t_index'(i);
            end
        end
        o_rx_hit.hit = |rx_match;
        o_rx_hit.index = rx_idx;
    end

    always_comb begin
        n_open = r_open;
        n_addr = r_addr;
        n_port = r_port;
        o_resp.status = udprx_pkg::ST_OK;
        o_resp.index = '0;
        unique case (i_req.opcode)
            udprx_pkg::OP_OPEN: begin
                if (free_any) begin
                    o_resp.index = free_idx;
                    for (int i = 0; i < ACTIVE_COUNT; i++) begin
                        if (free_idx == udprx_pkg::t_index'(i)) begin
                            n_open[i] = 1'b1;
                        end
                    end
                end else begin
                    o_resp.status = udprx_pkg::ST_TABLE_FULL;
                end
            end
            udprx_pkg::OP_BIND: begin
                if (!id_open) begin
                    o_resp.status = udprx_pkg::ST_BAD_SOCKET;
                end else if (|bind_match) begin
                    o_resp.status = udprx_pkg::ST_IN_USE;
                end else begin
                    o_resp.index = i_req.socket_id;
                    for (int i = 0; i < ACTIVE_COUNT; i++) begin
                        if (id_hot[i]) begin
                            n_addr[i] = i_req.bind_addr;
                            n_port[i] = i_req.bind_port;
                        end
                    end
                end
            end
            udprx_pkg::OP_CLOSE: begin
                if (!id_open) begin
                    o_resp.status = udprx_pkg::ST_BAD_SOCKET;
                end else begin
                    o_resp.index = i_req.socket_id;
                    for (int i = 0; i < ACTIVE_COUNT; i++) begin
                        if (id_hot[i]) begin
                            n_open[i] = 1'b0;
                            n_addr[i] = 32'd0;
                            n_port[i] = 16'd0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            for (int i = 0; i < ACTIVE_COUNT; i++) begin
                r_addr[i] <= 32'd0;
                r_port[i] <= 16'd0;
            end
        end else if (i_req.valid) begin
            r_open <= n_open;
            r_addr <= n_addr;
            r_port <= n_port;
        end
    end

    a_bind_ok_entry_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.opcode == udprx_pkg::OP_BIND &&
         o_resp.status == udprx_pkg::ST_OK) |=> (|(r_open & $past(id_hot))))
        else $error("Bound entry is not open.");

    a_close_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.opcode == udprx_pkg::OP_CLOSE &&
         o_resp.status == udprx_pkg::ST_OK) |=> ((r_open & $past(id_hot)) == '0))
        else $error("Closed entry is still open.");

endmodule

### sv/udprx_dgram_check.sv
// Datagram byte accumulator with header capture, checksum and length checks.
module udprx_dgram_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  udprx_pkg::t_req     i_req,
    output udprx_pkg::t_key     o_rx_key,
    output udprx_pkg::t_verdict o_verdict
);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_pend, n_pend;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [15:0] r_len, n_len;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_addr_sum, n_addr_sum;

    logic        rx;
    logic [15:0] cnt;
    logic [15:0] sum_step;
    logic [15:0] pad;
    logic [17:0] addr_raw;
    logic [16:0] addr_f1;
    logic [18:0] total;
    logic [16:0] total_f1;
    logic [15:0] total_f2;

    always_comb begin
        rx = i_req.valid && (i_req.opcode == udprx_pkg::OP_RECEIVE);
        cnt = (r_count == udprx_pkg::COUNT_MAX) ? r_count : r_count + 16'd1;
        sum_step = r_count[0] ? udprx_pkg::oc_add(r_sum, {r_pend, i_req.data_byte}) : r_sum;
        pad = cnt[0] ? {i_req.data_byte, 8'h00} : 16'h0000;

        addr_raw = {2'b0, i_req.src_addr[31:16]} + {2'b0, i_req.src_addr[15:0]} +
                   {2'b0, i_req.dst_addr[31:16]} + {2'b0, i_req.dst_addr[15:0]};
        addr_f1 = {1'b0, addr_raw[15:0]} + {15'b0, addr_raw[17:16]};

        total = {3'b0, sum_step} + {3'b0, pad} + {3'b0, r_addr_sum} +
                {3'b0, udprx_pkg::UDP_PROTOCOL} + {3'b0, cnt};
        total_f1 = {1'b0, total[15:0]} + {14'b0, total[18:16]};
        total_f2 = total_f1[15:0] + {15'b0, total_f1[16]};

        n_sum = sum_step;
        n_count = cnt;
        n_pend = r_count[0] ? r_pend : i_req.data_byte;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        n_len = r_len;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_addr_sum = r_addr_sum;
        if (r_count == 16'd0) begin
            n_src_addr = i_req.src_addr;
            n_dst_addr = i_req.dst_addr;
            n_addr_sum = addr_f1[15:0] + {15'b0, addr_f1[16]};
        end
        unique case (r_count)
            16'd0: n_src_port = {i_req.data_byte, 8'h00};
            16'd1: n_src_port = {r_src_port[15:8], i_req.data_byte};
            16'd2: n_dst_port = {i_req.data_byte, 8'h00};
            16'd3: n_dst_port = {r_dst_port[15:8], i_req.data_byte};
            16'd4: n_len = {i_req.data_byte, 8'h00};
            16'd5: n_len = {r_len[15:8], i_req.data_byte};
            default: begin
            end
        endcase

        o_verdict.done = rx && i_req.end_of_datagram;
        o_verdict.pass = 1'b0;
        o_verdict.peer_addr = r_src_addr;
        o_verdict.peer_port = r_src_port;
        o_verdict.payload_length = cnt - udprx_pkg::HEADER_BYTES;
        priority if (cnt < udprx_pkg::HEADER_BYTES) begin
            o_verdict.status = udprx_pkg::ST_SHORT;
        end else if (cnt == udprx_pkg::COUNT_MAX || cnt != r_len) begin
            o_verdict.status = udprx_pkg::ST_LEN_MISMATCH;
        end else if (total_f2 != udprx_pkg::SUM_ALL_ONES) begin
            o_verdict.status = udprx_pkg::ST_CSUM_BAD;
        end else begin
            o_verdict.status = udprx_pkg::ST_OK;
            o_verdict.pass = 1'b1;
        end

        o_rx_key.addr = r_dst_addr;
        o_rx_key.port = r_dst_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_verdict.done) begin
            r_sum <= '0;
            r_count <= '0;
            r_pend <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
            r_len <= '0;
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_addr_sum <= '0;
        end else if (rx) begin
            r_sum <= n_sum;
            r_count <= n_count;
            r_pend <= n_pend;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
            r_len <= n_len;
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_addr_sum <= n_addr_sum;
        end
    end

    a_final_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.done |=> (r_count == 16'd0 && r_sum == 16'd0))
        else $error("Receive state not cleared after the final byte.");

    a_count_never_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_count) == udprx_pkg::COUNT_MAX && r_count != 16'd0) |->
        r_count == udprx_pkg::COUNT_MAX)
        else $error("Byte count wrapped instead of saturating.");

endmodule

### sv/udp_receive_check_and_demux.sv
// Top level of the UDP receive checker and socket demultiplexer.
//
// Requests enter on start with the opcode and its operand ports; one is taken
// at every clock edge where start is high and busy is low. busy is set by reset,
// cleared at the first edge after it ends, so a request may follow every cycle.
// Opcodes: receive one datagram byte, open, bind or close a socket entry.
// Open, bind and close each give one result; a receive byte gives a result
// only when it carries the end-of-datagram mark, after the length, checksum
// and port checks.
// The request is registered at the accepting edge, the single pass through the
// table and the checker runs on the registered request, and the result is
// registered onto the output ports with o_strobe high for exactly one cycle.
// Throughput is one request per cycle while busy is low, set by the table
// update and the running checksum add.
// The receiver cannot stall; each result is taken at the edge ending its
// strobe cycle. Synchronous reset frees all socket entries, clears their
// bound endpoints and the partial datagram state, and drops any request in
// flight.
module udp_receive_check_and_demux #(
    parameter int SOCKET_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [3:0]  i_socket_id,
    input  logic [31:0] i_bind_addr,
    input  logic [15:0] i_bind_port,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [3:0]  o_socket_index,
    output logic [31:0] o_peer_addr,
    output logic [15:0] o_peer_port,
    output logic [15:0] o_payload_length
);

    logic                 r_busy;
    udprx_pkg::t_req      r_req, n_req;
    udprx_pkg::t_tbl_resp tbl_resp;
    udprx_pkg::t_lookup   rx_hit;
    udprx_pkg::t_key      rx_key;
    udprx_pkg::t_verdict  verdict;

    logic               r_strobe, n_strobe;
    udprx_pkg::t_status r_status, n_status;
    udprx_pkg::t_index  r_index, n_index;
    logic [31:0]        r_peer_addr, n_peer_addr;
    logic [15:0]        r_peer_port, n_peer_port;
    logic [15:0]        r_payload_length, n_payload_length;

    always_comb begin
        n_req.valid = start && !r_busy;
        n_req.opcode = udprx_pkg::t_opcode'(i_opcode);
        n_req.data_byte = i_data_byte;
        n_req.end_of_datagram = i_end_of_datagram;
        n_req.src_addr = i_src_addr;
        n_req.dst_addr = i_dst_addr;
        n_req.socket_id = i_socket_id;
        n_req.bind_addr = i_bind_addr;
        n_req.bind_port = i_bind_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_req.valid <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_req <= n_req;
        end
    end

    udprx_sock_table #(
        .SOCKET_COUNT(SOCKET_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_rx_key(rx_key),
        .o_resp  (tbl_resp),
        .o_rx_hit(rx_hit)
    );

    udprx_dgram_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_req),
        .o_rx_key (rx_key),
        .o_verdict(verdict)
    );

    always_comb begin
        n_strobe = r_req.valid;
        n_status = tbl_resp.status;
        n_index = tbl_resp.index;
        n_peer_addr = 32'd0;
        n_peer_port = 16'd0;
        n_payload_length = 16'd0;
        if (r_req.opcode == udprx_pkg::OP_RECEIVE) begin
            n_strobe = verdict.done;
            n_index = '0;
            n_status = verdict.status;
            if (verdict.pass) begin
                if (rx_hit.hit) begin
                    n_index = rx_hit.index;
                    n_peer_addr = verdict.peer_addr;
                    n_peer_port = verdict.peer_port;
                    n_payload_length = verdict.payload_length;
                end else begin
                    n_status = udprx_pkg::ST_UNBOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_status <= n_status;
        r_index <= n_index;
        r_peer_addr <= n_peer_addr;
        r_peer_port <= n_peer_port;
        r_payload_length <= n_payload_length;
    end

    assign busy = r_busy;
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_socket_index = r_index;
    assign o_peer_addr = r_peer_addr;
    assign o_peer_port = r_peer_port;
    assign o_payload_length = r_payload_length;

    a_strobe_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_req.valid))
        else $error("Result strobe without a request in the previous cycle.");

    a_reject_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != udprx_pkg::ST_OK) |->
        (r_index == '0 && r_peer_addr == 32'd0 && r_peer_port == 16'd0 &&
         r_payload_length == 16'd0))
        else $error("Rejected request carries nonzero result fields.");

endmodule
